// File: rtl/dfd_pkg.sv
`timescale 1ns / 1ps
// Package for the datagram frame deframer: result item type, status codes and
// header constants. No dependencies.
package dfd_pkg;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_BAD_ID    = 2'd1;
    localparam logic [1:0] STATUS_TRUNCATED = 2'd2;

    localparam logic [7:0] ID_LOW  = 8'h80;
    localparam logic [7:0] ID_HIGH = 8'h8F;

    // Bit r is set when reliability r carries that header field.
    localparam logic [7:0] MSG_INDEX_MASK = 8'hDC;
    localparam logic [7:0] ORDER_MASK     = 8'h9A;

    localparam logic [4:0] MSG_INDEX_BYTES = 5'd3;
    localparam logic [4:0] ORDER_BYTES     = 5'd4;
    localparam logic [4:0] SPLIT_BYTES     = 5'd10;

    localparam int LEN_W = 14;

    typedef struct packed {
        logic [1:0]  status;
        logic [23:0] sequence_number;
        logic        frame_last;
        logic        byte_valid;
        logic [7:0]  payload_byte;
    } res_t;

endpackage

// File: rtl/dfd_parser.sv
`timescale 1ns / 1ps
// Byte-wise datagram header and frame parser: holds the parse state and turns
// each accepted byte into at most one result item. Depends on dfd_pkg.
module dfd_parser (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          fire,
    input  logic [7:0]    in_byte,
    input  logic          datagram_last,
    output logic          res_valid,
    output dfd_pkg::res_t res
);

    localparam logic [2:0] PH_ID   = 3'd0;
    localparam logic [2:0] PH_SEQ  = 3'd1;
    localparam logic [2:0] PH_FLAG = 3'd2;
    localparam logic [2:0] PH_LHI  = 3'd3;
    localparam logic [2:0] PH_LLO  = 3'd4;
    localparam logic [2:0] PH_SKIP = 3'd5;
    localparam logic [2:0] PH_PAY  = 3'd6;

    logic [2:0]                 phase_reg, phase_next;
    logic [dfd_pkg::LEN_W-1:0]  left_reg, left_next;
    logic [dfd_pkg::LEN_W-1:0]  len_reg, len_next;
    logic [7:0]                 lhi_reg, lhi_next;
    logic [2:0]                 rel_reg, rel_next;
    logic                       split_reg, split_next;
    logic [23:0]                seq_reg, seq_next;
    logic                       drop_reg, drop_next;

    logic [16:0]                bits_round;
    logic [dfd_pkg::LEN_W-1:0]  len_calc;
    logic [dfd_pkg::LEN_W-1:0]  left_dec;
    logic [4:0]                 skip;
    logic                       emit;
    dfd_pkg::res_t              r;

    assign bits_round = {1'b0, lhi_reg, in_byte} + 17'd7;
    assign len_calc   = bits_round[16:3];
    assign left_dec   = (left_reg != '0) ? left_reg - 1'b1 : '0;

    always_comb begin
        skip = '0;
        if (dfd_pkg::MSG_INDEX_MASK[rel_reg]) skip = skip + dfd_pkg::MSG_INDEX_BYTES;
        if (dfd_pkg::ORDER_MASK[rel_reg])     skip = skip + dfd_pkg::ORDER_BYTES;
        if (split_reg)                        skip = skip + dfd_pkg::SPLIT_BYTES;
    end

    always_comb begin
        phase_next = phase_reg;
        left_next  = left_reg;
        len_next   = len_reg;
        lhi_next   = lhi_reg;
        rel_next   = rel_reg;
        split_next = split_reg;
        seq_next   = seq_reg;
        drop_next  = drop_reg;
        emit       = 1'b0;
        r          = '0;

        if (drop_reg) begin
            // Rest of a bad datagram: swallow bytes until its last one.
            if (datagram_last) begin
                drop_next  = 1'b0;
                phase_next = PH_ID;
            end
        end else begin
            unique case (phase_reg)
                PH_ID: begin
                    seq_next = '0;
                    if (in_byte < dfd_pkg::ID_LOW || in_byte > dfd_pkg::ID_HIGH) begin
                        emit       = 1'b1;
                        r.status   = dfd_pkg::STATUS_BAD_ID;
                        drop_next  = !datagram_last;
                        phase_next = PH_ID;
                    end else begin
                        left_next  = dfd_pkg::LEN_W'(3);
                        phase_next = PH_SEQ;
                    end
                end
                PH_SEQ: begin
                    // Little-endian: first byte is bits 7:0.
                    unique case (left_reg[1:0])
                        2'd3:    seq_next = seq_reg | {16'd0, in_byte};
                        2'd2:    seq_next = seq_reg | {8'd0, in_byte, 8'd0};
                        default: seq_next = seq_reg | {in_byte, 16'd0};
                    endcase
                    left_next = left_dec;
                    if (left_dec == '0) phase_next = PH_FLAG;
                end
                PH_FLAG: begin
                    rel_next   = in_byte[7:5];
                    split_next = in_byte[4];
                    phase_next = PH_LHI;
                end
                PH_LHI: begin
                    lhi_next   = in_byte;
                    phase_next = PH_LLO;
                end
                PH_LLO: begin
                    len_next = len_calc;
                    if (skip != '0) begin
                        left_next  = dfd_pkg::LEN_W'(skip);
                        phase_next = PH_SKIP;
                    end else if (len_calc == '0) begin
                        emit         = 1'b1;
                        r.frame_last = 1'b1;
                        phase_next   = PH_FLAG;
                    end else begin
                        left_next  = len_calc;
                        phase_next = PH_PAY;
                    end
                end
                PH_SKIP: begin
                    left_next = left_dec;
                    if (left_dec == '0) begin
                        if (len_reg == '0) begin
                            emit         = 1'b1;
                            r.frame_last = 1'b1;
                            phase_next   = PH_FLAG;
                        end else begin
                            left_next  = len_reg;
                            phase_next = PH_PAY;
                        end
                    end
                end
                PH_PAY: begin
                    emit           = 1'b1;
                    r.payload_byte = in_byte;
                    r.byte_valid   = 1'b1;
                    r.frame_last   = (left_reg <= dfd_pkg::LEN_W'(1));
                    left_next      = left_dec;
                    if (left_dec == '0) phase_next = PH_FLAG;
                end
                default: phase_next = PH_ID;
            endcase

            // A datagram that ends anywhere but between frames is truncated.
            // A bad id has already reported its datagram and is left as it is.
            if (datagram_last) begin
                if (phase_next != PH_FLAG && r.status != dfd_pkg::STATUS_BAD_ID) begin
                    emit     = 1'b1;
                    r.status = dfd_pkg::STATUS_TRUNCATED;
                end
                phase_next = PH_ID;
            end
        end

        r.sequence_number = seq_next;
    end

    assign res_valid = fire && emit;
    assign res       = r;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_ID;
            left_reg  <= '0;
            len_reg   <= '0;
            lhi_reg   <= '0;
            rel_reg   <= '0;
            split_reg <= 1'b0;
            seq_reg   <= '0;
            drop_reg  <= 1'b0;
        end else if (fire) begin
            phase_reg <= phase_next;
            left_reg  <= left_next;
            len_reg   <= len_next;
            lhi_reg   <= lhi_next;
            rel_reg   <= rel_next;
            split_reg <= split_next;
            seq_reg   <= seq_next;
            drop_reg  <= drop_next;
        end
    end

endmodule

// File: rtl/dfd_out_buf.sv
`timescale 1ns / 1ps
// Output register with a skid stage for result items, so the input side keeps
// running after the consumer stalls, until the skid fills. Depends on dfd_pkg.
module dfd_out_buf (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  dfd_pkg::res_t push_data,
    output logic          can_take,
    output logic          out_valid,
    input  logic          out_ready,
    output dfd_pkg::res_t out_data
);

    logic          out_valid_reg;
    dfd_pkg::res_t out_data_reg;
    logic          skid_valid_reg;
    dfd_pkg::res_t skid_data_reg;

    assign can_take  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_ready || !out_valid_reg) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= push;
            end
        end else if (push) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_ready || !out_valid_reg) begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : push_data;
        end else if (push) begin
            skid_data_reg <= push_data;
        end
    end

endmodule

// File: rtl/datagram_frame_deframer_top.sv
`timescale 1ns / 1ps
// Top level of the datagram frame deframer: byte-stream parser followed by a
// registered output with skid stage. Depends on dfd_pkg, dfd_parser, dfd_out_buf.
//
//  Channel   Direction  Carries
//  s_*       in         one raw datagram byte per item, tlast on the datagram's last byte
//  m_*       out        one result item: payload byte or empty/status marker,
//                       tlast on the last byte of a frame (or an empty frame)
//
// Each accepted byte is parsed in the cycle it arrives; its result item, if
// any, goes to the output register, or to the skid stage while m_* stalls.
// One byte is taken every cycle while s_tready is high. The skid stage lets
// s_tready stay high after m_tready drops; s_tready falls only once two results
// are waiting. Reset (aresetn, synchronous, active low) returns the parser to
// expecting a datagram id and empties the output stages.
module datagram_frame_deframer_top (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic        s_tlast,   // datagram_last

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [7:0] payload_byte, [31:8] sequence_number
    output logic        m_tlast,   // frame_last
    output logic [2:0]  m_tuser    // [0] byte_valid, [2:1] status
);

    logic          fire;
    logic          res_valid;
    dfd_pkg::res_t res;
    dfd_pkg::res_t out_res;

    // A byte is taken only when the output side has room for its result.
    assign fire = s_tvalid && s_tready;

    dfd_parser u_parser (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .fire          (fire),
        .in_byte       (s_tdata),
        .datagram_last (s_tlast),
        .res_valid     (res_valid),
        .res           (res)
    );

    dfd_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (res_valid),
        .push_data (res),
        .can_take  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_res)
    );

    assign m_tdata = {out_res.sequence_number, out_res.payload_byte};
    assign m_tlast = out_res.frame_last;
    assign m_tuser = {out_res.status, out_res.byte_valid};

endmodule
